### hw/rtl/bdm_pkg.sv
// ----------------------------------------------------------------------------
// bdm_pkg
// Shared constants and types for the BCD digit multiplexer.
// ----------------------------------------------------------------------------
`default_nettype none

package bdm_pkg;

   localparam int NUM_DIGITS = 4;

   function automatic int unsigned pow10(input int n);
      int unsigned p;
      p = 1;
      for (int i = 0; i < n; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

   // largest value shown, all nines
   localparam int unsigned SAT_BOUND = pow10(NUM_DIGITS) - 1;
   localparam int SAT_WIDTH = $clog2(SAT_BOUND + 1);
   localparam int BCD_WIDTH = NUM_DIGITS * 4;
   localparam int BIT_CNT_WIDTH = $clog2(SAT_WIDTH + 1);
   localparam int DIG_CNT_WIDTH = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic digit_shift;
   } conv_ctrl_type;

   typedef struct packed {
      logic [3:0] low_digit;
      logic       rest_zero;
   } conv_stat_type;

endpackage

`default_nettype wire

### hw/rtl/bcd_digit_multiplexer.sv
// ----------------------------------------------------------------------------
// bcd_digit_multiplexer
// Saturates a binary number to all nines, converts it to BCD and emits one
// item per significant digit, least significant first.
// ----------------------------------------------------------------------------
// channel   ports                                         handshake
// request   req_value_in                                  start & !busy
// response  rsp_digit_select, rsp_bcd_value, rsp_last_digit  rsp_valid strobe
//
// An item runs through one load, one shift-add-3 step per binary bit in
// bdm_dabble, then the emission of each significant digit. busy stays high
// until the last digit is out. Synchronous reset returns the sequencer to
// idle. Results are strobed for one cycle each and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_digit_multiplexer
   import bdm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_value_in,
   output logic             rsp_valid,
   output logic [1:0]       rsp_digit_select,
   output logic [3:0]       rsp_bcd_value,
   output logic             rsp_last_digit
);

   state_type                state_ff, state_in;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_WIDTH-1:0] dig_cnt_ff, dig_cnt_in;
   logic [SAT_WIDTH-1:0]     sat_value;
   logic                     accept;
   logic                     last;
   conv_ctrl_type            ctrl;
   conv_stat_type            stat;

   assign accept = start && (state_ff == ST_IDLE);
   assign sat_value = (req_value_in > 32'(SAT_BOUND)) ? SAT_WIDTH'(SAT_BOUND)
                                                      : req_value_in[SAT_WIDTH-1:0];
   assign last = stat.rest_zero || (dig_cnt_ff == DIG_CNT_WIDTH'(NUM_DIGITS - 1));

   bdm_dabble u_dabble (
      .clock      (clock),
      .ctrl       (ctrl),
      .load_value (sat_value),
      .stat       (stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == BIT_CNT_WIDTH'(1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      ctrl       = '0;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      busy       = 1'b1;
      rsp_valid  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy       = 1'b0;
            ctrl.load  = accept;
            bit_cnt_in = BIT_CNT_WIDTH'(SAT_WIDTH);
            dig_cnt_in = '0;
         end
         ST_CONVERT: begin
            ctrl.dabble = 1'b1;
            bit_cnt_in  = bit_cnt_ff - BIT_CNT_WIDTH'(1);
         end
         ST_EMIT: begin
            rsp_valid        = 1'b1;
            ctrl.digit_shift = 1'b1;
            dig_cnt_in       = dig_cnt_ff + DIG_CNT_WIDTH'(1);
         end
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
      end
   end

   assign rsp_digit_select = 2'(dig_cnt_ff);
   assign rsp_bcd_value    = stat.low_digit;
   assign rsp_last_digit   = last;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("busy not raised after item accepted");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bcd_value <= 4'd9))
      else $error("digit out of BCD range");

   a_first_digit_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> (dig_cnt_ff == '0))
      else $error("run does not start at position zero");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_digit) |=> (!busy && !rsp_valid))
      else $error("sequencer not idle after last digit");
`endif

endmodule

`default_nettype wire

### hw/rtl/bdm_dabble.sv
// ----------------------------------------------------------------------------
// bdm_dabble
// Bit-serial shift-and-add-3 binary to BCD converter with digit shift-out.
// ----------------------------------------------------------------------------
`default_nettype none

module bdm_dabble
   import bdm_pkg::*;
(
   input  wire logic                 clock,
   input  wire conv_ctrl_type        ctrl,
   input  wire logic [SAT_WIDTH-1:0] load_value,
   output conv_stat_type             stat
);

   logic [SAT_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0] bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0] bcd_adj;

   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] >= 4'd5) begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = load_value;
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         bin_in = {bin_ff[SAT_WIDTH-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_WIDTH-2:0], bin_ff[SAT_WIDTH-1]};
      end else if (ctrl.digit_shift) begin
         bcd_in = bcd_ff >> 4;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign stat.low_digit = bcd_ff[3:0];
   assign stat.rest_zero = ((bcd_ff >> 4) == '0);

endmodule

`default_nettype wire

### verif/tb_bcd_digit_multiplexer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bcd_digit_multiplexer
// Self-checking bench for the BCD digit multiplexer. Each number sent is run
// through a local digit predictor (saturation to all nines, decimal split,
// leading-zero suppression) and every strobed digit is checked against the
// oldest predicted one. Directed edge values come first, then a random mix
// with random sender gaps, gap-free bursts and a full drain part-way through.
// ----------------------------------------------------------------------------

module tb_bcd_digit_multiplexer;
   import bdm_pkg::*;

   typedef struct {
      logic [1:0] sel;
      logic [3:0] bcd;
      logic       last;
   } shown_digit_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_value_in = '0;
   logic        busy;
   logic        rsp_valid;
   logic [1:0]  rsp_digit_select;
   logic [3:0]  rsp_bcd_value;
   logic        rsp_last_digit;

   shown_digit_type pending_digits[$];
   int              error_count = 0;
   bit              gapless = 1'b0;

   bcd_digit_multiplexer u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value_in     (req_value_in),
      .rsp_valid        (rsp_valid),
      .rsp_digit_select (rsp_digit_select),
      .rsp_bcd_value    (rsp_bcd_value),
      .rsp_last_digit   (rsp_last_digit)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end

   // expected digits of one number, least significant first
   function automatic void predict_digits(input logic [31:0] value);
      longint unsigned bound;
      longint unsigned v;
      int              count;
      shown_digit_type d;
      bound = 1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bound = bound * 10;
      end
      bound = bound - 1;
      v = value;
      if (v > bound) begin
         v = bound;
      end
      if (v == 0) begin
         d.sel  = '0;
         d.bcd  = '0;
         d.last = 1'b1;
         pending_digits.push_back(d);
         return;
      end
      count = 0;
      while (v != 0 && count < NUM_DIGITS) begin
         d.sel  = 2'(count);
         d.bcd  = 4'(v % 10);
         d.last = (v < 10) || (count == NUM_DIGITS - 1);
         pending_digits.push_back(d);
         v = v / 10;
         count++;
      end
   endfunction

   task automatic send_value(input logic [31:0] value);
      int gap;
      gap = gapless ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_value_in <= value;
      do begin
         @(posedge clock);
      end while (busy);
      predict_digits(value);
   endtask

   task automatic wait_display_idle();
      start <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      shown_digit_type exp_d;
      if (!reset && rsp_valid) begin
         if (pending_digits.size() == 0) begin
            $display("%0t: unexpected digit sel=%0d bcd=%0d last=%0d", $time,
                     rsp_digit_select, rsp_bcd_value, rsp_last_digit);
            error_count++;
         end else begin
            exp_d = pending_digits.pop_front();
            if (rsp_digit_select !== exp_d.sel) begin
               $display("%0t: digit_select expected %0d, actual %0d", $time,
                        exp_d.sel, rsp_digit_select);
               error_count++;
            end
            if (rsp_bcd_value !== exp_d.bcd) begin
               $display("%0t: bcd_value expected %0d, actual %0d", $time,
                        exp_d.bcd, rsp_bcd_value);
               error_count++;
            end
            if (rsp_last_digit !== exp_d.last) begin
               $display("%0t: last_digit expected %0d, actual %0d", $time,
                        exp_d.last, rsp_last_digit);
               error_count++;
            end
         end
      end
   end

   // zero, single digit up to full width, inner zeros
   task automatic test_digit_extremes();
      logic [31:0] values[$];
      values = '{0, 1, 9, 10, 99, 100, 909, 1000, 9999, 1234, 5070, 9990, 8001, 7, 50,
                 600, 4321};
      foreach (values[i]) send_value(values[i]);
   endtask

   // values above the bound show as all nines
   task automatic test_saturation();
      logic [31:0] values[$];
      values = '{10000, 10001, 32'hFFFF_FFFF, 32'h8000_0000, 65536, 32'h5555_5555,
                 32'hAAAA_AAAA};
      foreach (values[i]) send_value(values[i]);
   endtask

   // sender holds off until the display has gone quiet
   task automatic test_drain_pause();
      send_value(3);
      send_value(2468);
      wait_display_idle();
      send_value(9999);
      send_value(0);
      wait_display_idle();
   endtask

   task automatic test_random_mix(input int n_items);
      logic [31:0] v;
      for (int i = 0; i < n_items; i++) begin
         if (i % 20 == 0) begin
            gapless = ($urandom_range(0, 3) == 0);
         end
         case ($urandom_range(0, 9))
            0:       v = $urandom();
            1:       v = $urandom_range(0, 9);
            2:       v = $urandom_range(10, 99);
            3:       v = $urandom_range(100, 999);
            4:       v = $urandom_range(9990, 10010);
            5:       v = 32'd1 << $urandom_range(0, 31);
            default: v = $urandom_range(0, 9999);
         endcase
         send_value(v);
         if (i == n_items / 2) begin
            wait_display_idle();
         end
      end
      gapless = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_digit_extremes();
      test_saturation();
      test_drain_pause();
      test_random_mix(302);
      wait_display_idle();
      repeat (25) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
